// File: rtl/iirdf1_pkg.sv
// Shared constants and types for the direct form I IIR filter.
package iirdf1_pkg;

    localparam int COEF_BITS    = 24;
    localparam int CFG_BITS     = 2 * COEF_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FF0_FF1 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF2_FF3 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF4_FB1 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB2_FB3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB4     = 3'd4;

    localparam int HIST_DEPTH = 4;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // nine taps per item: ff0..ff4 then fb1..fb4
    localparam int TAP_CNT = 9;
    localparam int TAP_W   = $clog2(TAP_CNT);
    localparam logic [TAP_W-1:0] FB_FIRST_TAP = 4'd5;

    localparam int DEF_FF_TAPS        = 5;
    localparam int DEF_FB_TAPS        = 5;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 20;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic use_x;
        logic use_fb;
    } mac_ctrl_t;

endpackage

// File: rtl/iirdf1_hist_mem.sv
// History memory with per-entry valid bits; invalid entries read as zero.
module iirdf1_hist_mem
    import iirdf1_pkg::*;
#(
    parameter int DATA_W = DEF_SAMPLE_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  logic               wr_en,
    input  logic [HIST_AW-1:0] wr_addr,
    input  logic [DATA_W-1:0]  wr_data,
    input  logic [HIST_AW-1:0] rd_addr,
    output logic [DATA_W-1:0]  rd_data
);

    logic [DATA_W-1:0]     ram [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] vld_reg;
    logic [DATA_W-1:0]     rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (clear) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        rd_data_reg <= vld_reg[rd_addr] ? ram[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/iirdf1_cfg.sv
// Coefficient registers and per-tap coefficient select.
module iirdf1_cfg
    import iirdf1_pkg::*;
#(
    parameter int FF_TAPS        = DEF_FF_TAPS,
    parameter int FB_TAPS        = DEF_FB_TAPS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data,
    input  logic [TAP_W-1:0]            tap,
    output logic signed [COEF_BITS-1:0] coef
);

    logic [CFG_BITS-1:0]  ff01_reg;
    logic [CFG_BITS-1:0]  ff23_reg;
    logic [CFG_BITS-1:0]  ff4fb1_reg;
    logic [CFG_BITS-1:0]  fb23_reg;
    logic [COEF_BITS-1:0] fb4_reg;
    logic [COEF_BITS-1:0] coef_sel;
    logic [COEF_BITS-1:0] coef_next;
    logic [COEF_BITS-1:0] coef_reg;
    logic [TAP_W-1:0]     fb_idx;
    logic                 tap_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff01_reg   <= CFG_BITS'(1) << COEF_FRAC_BITS;
            ff23_reg   <= '0;
            ff4fb1_reg <= '0;
            fb23_reg   <= '0;
            fb4_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_FF0_FF1: ff01_reg   <= cfg_data;
                REG_FF2_FF3: ff23_reg   <= cfg_data;
                REG_FF4_FB1: ff4fb1_reg <= cfg_data;
                REG_FB2_FB3: fb23_reg   <= cfg_data;
                REG_FB4:     fb4_reg    <= cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (tap)
            4'd0:    coef_sel = ff01_reg[COEF_BITS-1:0];
            4'd1:    coef_sel = ff01_reg[CFG_BITS-1:COEF_BITS];
            4'd2:    coef_sel = ff23_reg[COEF_BITS-1:0];
            4'd3:    coef_sel = ff23_reg[CFG_BITS-1:COEF_BITS];
            4'd4:    coef_sel = ff4fb1_reg[COEF_BITS-1:0];
            4'd5:    coef_sel = ff4fb1_reg[CFG_BITS-1:COEF_BITS];
            4'd6:    coef_sel = fb23_reg[COEF_BITS-1:0];
            4'd7:    coef_sel = fb23_reg[CFG_BITS-1:COEF_BITS];
            4'd8:    coef_sel = fb4_reg;
            default: coef_sel = '0;
        endcase
    end

    // feedback tap k sits at position k + FB_FIRST_TAP - 1
    assign fb_idx   = tap - (FB_FIRST_TAP - TAP_W'(1));
    assign tap_used = (tap < FB_FIRST_TAP) ? (tap < TAP_W'(FF_TAPS))
                                           : (fb_idx < TAP_W'(FB_TAPS));
    assign coef_next = tap_used ? coef_sel : '0;

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

    assign coef = $signed(coef_reg);

endmodule

// File: rtl/iirdf1_mac.sv
// Shared multiply-accumulate with floor shift and saturation.
module iirdf1_mac
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mac_ctrl_t                     ctrl,
    input  logic signed [COEF_BITS-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] in_hist,
    input  logic signed [SAMPLE_BITS-1:0] out_hist,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] y
);

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 4;
    localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [SAMPLE_BITS-1:0] operand;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;
    mac_ctrl_t                     ctrl1_reg;
    logic signed [ACC_W-1:0]       acc_base;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       acc_reg;
    logic                          done_reg;
    logic signed [ACC_W-1:0]       shifted;
    logic signed [ACC_W-1:0]       sat;

    assign operand   = ctrl.use_x ? x : (ctrl.use_fb ? out_hist : in_hist);
    assign prod_next = coef * operand;

    assign acc_base = ctrl1_reg.first ? '0 : acc_reg;
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_next = ctrl1_reg.use_fb ? (acc_base - prod_ext) : (acc_base + prod_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            ctrl1_reg <= ctrl;
            done_reg  <= ctrl1_reg.vld && ctrl1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctrl1_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    assign shifted = acc_reg >>> COEF_FRAC_BITS;
    assign sat     = (shifted > SAT_MAX) ? SAT_MAX :
                     (shifted < SAT_MIN) ? SAT_MIN : shifted;

    assign done = done_reg;
    assign y    = sat[SAMPLE_BITS-1:0];

endmodule

// File: rtl/iir_direct_form_one_filter.sv
// Direct form I IIR filter top level: tap sequencer, history memories and MAC.
// One item is handled at a time: each filter item makes a nine-tap pass through the single
// multiplier and the history memories' single read port.
// Reset: synchronous, active low; histories read as zero, ff0 = 1.0, others zero.
// A clear item invalidates both histories together and returns a zero sample.
module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int FF_TAPS        = DEF_FF_TAPS,
    parameter int FB_TAPS        = DEF_FB_TAPS,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [TAP_W-1:0]       tap_reg, tap_next;
    logic [HIST_AW-1:0]     ptr_reg, ptr_next;
    logic                   cmd_reg, cmd_next;
    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    mac_ctrl_t              ctrl_reg, ctrl_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_data_reg, m_data_next;

    logic                   wr_en;
    logic                   hist_clear;
    logic [TAP_W-1:0]       hist_idx;
    logic [HIST_AW-1:0]     rd_addr;
    logic [SAMPLE_BITS-1:0] in_hist;
    logic [SAMPLE_BITS-1:0] out_hist;
    logic signed [COEF_BITS-1:0]   coef;
    logic                   mac_done;
    logic signed [SAMPLE_BITS-1:0] mac_y;

    // most recent entry sits just below the write pointer
    assign hist_idx = (tap_reg < FB_FIRST_TAP) ? (tap_reg - TAP_W'(1))
                                               : (tap_reg - FB_FIRST_TAP);
    assign rd_addr  = ptr_reg - HIST_AW'(1) - hist_idx[HIST_AW-1:0];

    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        ptr_next     = ptr_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        ctrl_next    = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        hist_clear   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    x_next     = s_sample_in;
                    tap_next   = '0;
                    state_next = (s_command == CMD_CLEAR) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                ctrl_next.vld    = 1'b1;
                ctrl_next.first  = (tap_reg == '0);
                ctrl_next.last   = (tap_reg == TAP_W'(TAP_CNT - 1));
                ctrl_next.use_x  = (tap_reg == '0);
                ctrl_next.use_fb = (tap_reg >= FB_FIRST_TAP);
                tap_next         = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(TAP_CNT - 1)) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (cmd_reg == CMD_CLEAR) begin
                        m_data_next = '0;
                        hist_clear  = 1'b1;
                    end else begin
                        m_data_next = mac_y;
                        wr_en       = 1'b1;
                        ptr_next    = ptr_reg + HIST_AW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tap_reg     <= '0;
            ptr_reg     <= '0;
            cmd_reg     <= CMD_FILTER;
            ctrl_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            ptr_reg     <= ptr_next;
            cmd_reg     <= cmd_next;
            ctrl_reg    <= ctrl_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg      <= x_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;
    assign cfg_ready    = 1'b1;

    iirdf1_cfg #(
        .FF_TAPS        (FF_TAPS),
        .FB_TAPS        (FB_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tap       (tap_reg),
        .coef      (coef)
    );

    iirdf1_hist_mem #(
        .DATA_W (SAMPLE_BITS)
    ) u_in_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (hist_clear),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (x_reg),
        .rd_addr (rd_addr),
        .rd_data (in_hist)
    );

    iirdf1_hist_mem #(
        .DATA_W (SAMPLE_BITS)
    ) u_out_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (hist_clear),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (mac_y),
        .rd_addr (rd_addr),
        .rd_data (out_hist)
    );

    iirdf1_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl_reg),
        .coef     (coef),
        .x        ($signed(x_reg)),
        .in_hist  ($signed(in_hist)),
        .out_hist ($signed(out_hist)),
        .done     (mac_done),
        .y        (mac_y)
    );

endmodule

// File: tb/iir_direct_form_one_filter_tb.sv
// Self-checking testbench for the direct form I IIR filter: predicted samples against the DUT.
module iir_direct_form_one_filter_tb;
    import iirdf1_pkg::*;

    localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
    localparam int FRAC_W        = DEF_COEF_FRAC_BITS;
    localparam int REG_COUNT     = 5;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_IDLE      = 18;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 15;
    localparam int PHASE_ITEMS   = 127;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_MAX     = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN     = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_ONE     = COEF_BITS'(1) << FRAC_W;
    localparam logic [COEF_BITS-1:0] COEF_NEG_ONE = -(COEF_BITS'(1) << FRAC_W);

    typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;
    typedef enum int {STYLE_RESET, STYLE_STABLE, STYLE_WILD, STYLE_EDGE} coef_style_t;

    typedef struct {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample;
    } sample_item_t;

    logic                       aclk;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic                       s_command    = CMD_FILTER;
    logic signed [SAMPLE_W-1:0] s_sample_in  = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index    = '0;
    logic [CFG_BITS-1:0]        cfg_data     = '0;

    // filter state as the DUT should hold it
    logic [CFG_BITS-1:0]        coef_regs [REG_COUNT];
    logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];

    sample_item_t               pending_items [$];
    logic signed [SAMPLE_W-1:0] expected_outputs [$];
    sample_item_t               next_item;
    logic signed [SAMPLE_W-1:0] want;

    idle_mode_t sender_idle   = IDLE_NONE;
    idle_mode_t receiver_idle = IDLE_NONE;
    int         sender_gap    = 0;
    int         receiver_gap  = 0;
    int         items_queued   = 0;
    int         items_accepted = 0;
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;

    iir_direct_form_one_filter i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int idle_draw(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
            default:   return $urandom_range(0, MAX_IDLE);
        endcase
    endfunction

    function automatic void filter_reset();
        coef_regs[REG_FF0_FF1] = CFG_BITS'(COEF_ONE);
        for (int r = 1; r < REG_COUNT; r++) coef_regs[r] = '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_predict(
        logic command, logic signed [SAMPLE_W-1:0] x);
        logic signed [COEF_BITS-1:0] ff [DEF_FF_TAPS];
        logic signed [COEF_BITS-1:0] fb [DEF_FB_TAPS];
        longint acc;
        longint y;
        if (command == CMD_CLEAR) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            return '0;
        end
        ff[0] = coef_regs[REG_FF0_FF1][0 +: COEF_BITS];
        ff[1] = coef_regs[REG_FF0_FF1][COEF_BITS +: COEF_BITS];
        ff[2] = coef_regs[REG_FF2_FF3][0 +: COEF_BITS];
        ff[3] = coef_regs[REG_FF2_FF3][COEF_BITS +: COEF_BITS];
        ff[4] = coef_regs[REG_FF4_FB1][0 +: COEF_BITS];
        fb[0] = '0;
        fb[1] = coef_regs[REG_FF4_FB1][COEF_BITS +: COEF_BITS];
        fb[2] = coef_regs[REG_FB2_FB3][0 +: COEF_BITS];
        fb[3] = coef_regs[REG_FB2_FB3][COEF_BITS +: COEF_BITS];
        fb[4] = coef_regs[REG_FB4][0 +: COEF_BITS];
        acc = longint'(ff[0]) * longint'(x);
        for (int i = 1; i < DEF_FF_TAPS; i++)
            acc += longint'(ff[i]) * longint'(x_hist[i-1]);
        for (int i = 1; i < DEF_FB_TAPS; i++)
            acc -= longint'(fb[i]) * longint'(y_hist[i-1]);
        y = acc >>> FRAC_W;
        if (y > longint'(S_MAX)) y = longint'(S_MAX);
        if (y < longint'(S_MIN)) y = longint'(S_MIN);
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            x_hist[i] = x_hist[i-1];
            y_hist[i] = y_hist[i-1];
        end
        x_hist[0] = x;
        y_hist[0] = SAMPLE_W'(y);
        return SAMPLE_W'(y);
    endfunction

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            sender_gap = 0;
            filter_reset();
        end else begin
            if (s_valid && s_ready) begin
                expected_outputs.push_back(filter_predict(s_command, s_sample_in));
                items_accepted++;
                sender_gap = idle_draw(sender_idle);
            end
            if (!s_valid || s_ready) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_command   <= next_item.command;
                    s_sample_in <= next_item.sample;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            receiver_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: item with none expected, sample_out %0d",
                                 $time, m_sample_out);
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_sample_out !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: sample_out expected %0d, got %0d",
                                     $time, want, m_sample_out);
                    end
                end
                receiver_gap = idle_draw(receiver_idle);
            end
            if (receiver_gap > 0) begin
                receiver_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic queue_item(logic command, logic signed [SAMPLE_W-1:0] sample);
        sample_item_t it;
        it.command = command;
        it.sample  = sample;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic write_coef(logic [CFG_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_FB4)
            coef_regs[index] = {{(CFG_BITS-COEF_BITS){1'b0}}, value[COEF_BITS-1:0]};
        else if (index < REG_COUNT)
            coef_regs[index] = value;
    endtask

    // wait for every item to go through, then let the pipeline settle
    task automatic drain();
        while (items_accepted != items_queued || expected_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
            4:       return SAMPLE_W'(int'($urandom_range(0, 16382)) - 8191);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] draw_coef(coef_style_t style, int tap);
        logic feedback;
        feedback = (tap >= FB_FIRST_TAP);
        case (style)
            STYLE_RESET:
                return (tap == 0) ? COEF_ONE : '0;
            STYLE_STABLE:
                // feedback kept under 0.2 per tap so the poles stay inside
                return feedback ? COEF_BITS'(int'($urandom_range(0, 419430)) - 209715)
                                : COEF_BITS'(int'($urandom_range(0, 1048576)) - 524288);
            STYLE_WILD:
                return COEF_BITS'($urandom);
            default:
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return COEF_ONE;
                    3:       return COEF_NEG_ONE;
                    default: return '0;
                endcase
        endcase
    endfunction

    task automatic load_coefs(coef_style_t style);
        logic [COEF_BITS-1:0] c [TAP_CNT];
        for (int i = 0; i < TAP_CNT; i++) c[i] = draw_coef(style, i);
        write_coef(REG_FF0_FF1, {c[1], c[0]});
        write_coef(REG_FF2_FF3, {c[3], c[2]});
        write_coef(REG_FF4_FB1, {c[5], c[4]});
        write_coef(REG_FB2_FB3, {c[7], c[6]});
        write_coef(REG_FB4, {COEF_BITS'($urandom), c[8]});
    endtask

    initial begin
        coef_style_t style;
        while (!aresetn) @(posedge aclk);

        // reset coefficients pass the sample straight through
        queue_item(CMD_FILTER, S_MAX);
        queue_item(CMD_FILTER, S_MIN);
        queue_item(CMD_FILTER, '0);
        queue_item(CMD_FILTER, -1);
        queue_item(CMD_FILTER, 1);
        queue_item(CMD_FILTER, 24'h555555);
        queue_item(CMD_FILTER, 24'haaaaaa);
        queue_item(CMD_CLEAR, S_MAX);
        queue_item(CMD_FILTER, 24'h123456);
        drain();

        // writes past the last register must leave the filter alone
        for (int r = REG_COUNT; r < 2**CFG_IDX_BITS; r++)
            write_coef(CFG_IDX_BITS'(r), '1);
        queue_item(CMD_FILTER, 24'h400000);
        drain();

        // full-scale gains with negative feedback coefficients: saturates both ways
        write_coef(REG_FF0_FF1, {COEF_MAX, COEF_MAX});
        write_coef(REG_FF2_FF3, {COEF_MAX, COEF_MAX});
        write_coef(REG_FF4_FB1, {COEF_MIN, COEF_MAX});
        write_coef(REG_FB2_FB3, {COEF_MIN, COEF_MIN});
        write_coef(REG_FB4, {{COEF_BITS{1'b1}}, COEF_MIN});
        queue_item(CMD_FILTER, S_MAX);
        queue_item(CMD_FILTER, S_MAX);
        queue_item(CMD_FILTER, S_MIN);
        queue_item(CMD_FILTER, S_MIN);
        queue_item(CMD_FILTER, S_MIN);
        queue_item(CMD_CLEAR, S_MIN);
        queue_item(CMD_FILTER, 1);
        queue_item(CMD_FILTER, -1);
        queue_item(CMD_FILTER, '0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            style = coef_style_t'(p % 4);
            load_coefs(style);
            if ($urandom_range(0, 2) == 0)
                write_coef(CFG_IDX_BITS'($urandom_range(REG_COUNT, 2**CFG_IDX_BITS - 1)),
                           CFG_BITS'({$urandom, $urandom}));
            sender_idle   = (p == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
            receiver_idle = (p == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_item(($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_FILTER,
                           draw_sample());
            drain();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
